@@ rtl/core/sil_pkg.sv @@
// Package for the sorted insert list: request and result payload types,
// request and status codes, and the control bundle sent to every cell.
// No dependencies.
`default_nettype none

package sil_pkg;

    typedef enum logic [0:0] {
        REQ_ADD = 1'b0,
        REQ_POP = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_ADD_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_req_type          req_type;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [4:0]         entry_count;
        t_status            status;
    } t_res;

    // Shift commands broadcast to the row of cells.
    typedef struct packed {
        logic do_add;
        logic do_pop;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ rtl/core/sil_cell.sv @@
// One storage cell of the sorted insert list: holds a single entry, compares
// it with the incoming value and takes its own, its neighbour's or the new value.
// Depends on sil_pkg.
`default_nettype none

module sil_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                     i_clk,
    input  sil_pkg::t_cell_ctrl     i_ctrl,
    input  wire                     i_occupied,
    input  wire [VALUE_WIDTH-1:0]   i_new_value,
    input  wire [VALUE_WIDTH-1:0]   i_left_value,
    input  wire                     i_left_lt,
    input  wire [VALUE_WIDTH-1:0]   i_right_value,
    output logic [VALUE_WIDTH-1:0]  o_value,
    output logic                    o_lt
);
    import sil_pkg::*;

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    // A cell stays put on insertion while its entry is strictly smaller.
    assign o_lt    = i_occupied && ($signed(r_value) < $signed(i_new_value));
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.do_add) begin
            if (o_lt) begin
                n_value = r_value;
            end else if (i_left_lt) begin
                n_value = i_new_value;
            end else begin
                n_value = i_left_value;
            end
        end else if (i_ctrl.do_pop) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

@@ rtl/core/sorted_insert_list.sv @@
// Sorted insert list: a row of CAPACITY cells keeps the values in ascending order.
// Latency: the result of a request is valid in the cycle after it is accepted.
// Throughput: one request per cycle while the result is taken; all cells compare and shift together.
// A request is accepted while the result register is empty or being emptied.
// Reset clears the entry count and the result valid flag; no clearing pass.
`default_nettype none

module sorted_insert_list #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  sil_pkg::t_req  i_req,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output sil_pkg::t_res  o_res
);
    import sil_pkg::*;

    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int WIDE_W  = VALUE_WIDTH + 32;
    localparam int CNT_W   = CW + 5;

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_out_valid;
    logic                    n_out_valid;
    t_res                    r_out;
    t_res                    n_out;

    logic                    in_fire;
    logic                    add_ok;
    logic                    pop_ok;
    t_cell_ctrl              ctrl;
    logic [WIDE_W-1:0]       in_wide;
    logic [WIDE_W-1:0]       pop_wide;
    logic [CNT_W-1:0]        cnt_wide;
    logic [VALUE_WIDTH-1:0]  new_value;

    logic [VALUE_WIDTH-1:0]  cell_value [CAPACITY];
    logic                    cell_lt    [CAPACITY];

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    assign in_wide   = WIDE_W'($unsigned(i_req.value));
    assign new_value = in_wide[VALUE_WIDTH-1:0];
    assign pop_wide  = WIDE_W'(cell_value[0]);

    assign add_ok      = (i_req.req_type == REQ_ADD) && (r_count < CW'(CAPACITY));
    assign pop_ok      = (i_req.req_type == REQ_POP) && (r_count != '0);
    assign ctrl.do_add = in_fire && add_ok;
    assign ctrl.do_pop = in_fire && pop_ok;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;
        logic                   left_lt;
        logic [VALUE_WIDTH-1:0] right_value;

        if (g == 0) begin : g_head
            assign left_value = new_value;
            assign left_lt    = 1'b0;
        end else begin : g_body
            assign left_value = cell_value[g-1];
            assign left_lt    = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_value = cell_value[g];
        end else begin : g_inner
            assign right_value = cell_value[g+1];
        end

        sil_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occupied    (CW'(g) < r_count),
            .i_new_value   (new_value),
            .i_left_value  (left_value),
            .i_left_lt     (left_lt),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (ctrl.do_add) begin
            n_count = r_count + CW'(1);
        end else if (ctrl.do_pop) begin
            n_count = r_count - CW'(1);
        end
        cnt_wide = CNT_W'(n_count);
        if (in_fire) begin
            n_out_valid        = 1'b1;
            n_out.entry_count  = cnt_wide[4:0];
            n_out.popped_value = pop_ok ? pop_wide[31:0] : 32'sd0;
            if (i_req.req_type == REQ_POP) begin
                n_out.status = pop_ok ? ST_OK : ST_POP_EMPTY;
            end else begin
                n_out.status = add_ok ? ST_OK : ST_ADD_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.do_add |=> r_count == $past(r_count) + CW'(1))
        else $error("count did not rise after an insertion");

    a_error_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !add_ok && !pop_ok) |=> r_count == $past(r_count))
        else $error("rejected request changed the count");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_POP_EMPTY) |->
            (r_out.entry_count == 5'd0 && r_out.popped_value == 32'sd0))
        else $error("pop on empty store reported data or a count");

endmodule

`default_nettype wire

@@ dv/sil_tb_pkg.sv @@
// Scoreboard for the sorted insert list testbench: keeps its own sorted copy of
// the list, predicts one result per accepted request and checks results in order.
// Depends on sil_pkg for the request and result payload types.
package sil_tb_pkg;
    import sil_pkg::*;

    localparam int LIST_DEPTH = 16;

    class sorted_list_checker;
        logic signed [31:0] list_values [LIST_DEPTH];
        int unsigned        list_count = 0;
        t_res               expected_results [$];
        int unsigned        mismatches = 0;
        int unsigned        adds_done = 0;
        int unsigned        adds_refused = 0;
        int unsigned        pops_done = 0;
        int unsigned        pops_refused = 0;
        int unsigned        deepest = 0;

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // Applies an accepted request to the local list and queues its result.
        function void note_request(t_req r);
            t_res        res;
            int unsigned pos;
            int unsigned idx;
            res.popped_value = '0;
            res.status       = ST_OK;
            if (r.req_type == REQ_ADD) begin
                if (list_count >= LIST_DEPTH) begin
                    res.status = ST_ADD_FULL;
                    adds_refused++;
                end else begin
                    // The new value goes in front of the first stored value that is
                    // not smaller than it.
                    pos = 0;
                    while (pos < list_count && list_values[pos] < $signed(r.value)) begin
                        pos++;
                    end
                    for (idx = list_count; idx > pos; idx--) begin
                        list_values[idx] = list_values[idx - 1];
                    end
                    list_values[pos] = r.value;
                    list_count++;
                    adds_done++;
                end
            end else begin
                if (list_count == 0) begin
                    res.status = ST_POP_EMPTY;
                    pops_refused++;
                end else begin
                    res.popped_value = list_values[0];
                    for (idx = 1; idx < list_count; idx++) begin
                        list_values[idx - 1] = list_values[idx];
                    end
                    list_count--;
                    pops_done++;
                end
            end
            if (list_count > deepest) begin
                deepest = list_count;
            end
            res.entry_count = 5'(list_count);
            expected_results.push_back(res);
        endfunction

        task check_result(t_res got);
            t_res want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf(
                    "result with nothing expected: value %0d count %0d status %0d",
                    got.popped_value, got.entry_count, got.status));
                return;
            end
            want = expected_results.pop_front();
            if (got.popped_value !== want.popped_value) begin
                report_mismatch($sformatf("popped_value %0d, expected %0d",
                                          got.popped_value, want.popped_value));
            end
            if (got.entry_count !== want.entry_count) begin
                report_mismatch($sformatf("entry_count %0d, expected %0d",
                                          got.entry_count, want.entry_count));
            end
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            end
        endtask

        task flush_leftovers();
            t_res want;
            while (expected_results.size() != 0) begin
                want = expected_results.pop_front();
                report_mismatch($sformatf(
                    "result never arrived: value %0d count %0d status %0d",
                    want.popped_value, want.entry_count, want.status));
            end
        endtask
    endclass

endpackage

@@ dv/tb_top.sv @@
// Top level of the sorted insert list testbench: clock, reset, request driver
// with bursts and gaps, result receiver with its own stall pattern.
// Depends on sil_pkg, sil_tb_pkg and the sorted_insert_list RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sil_pkg::*;
    import sil_tb_pkg::*;

    localparam int RANDOM_REQUESTS = 750;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_req req       = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_res res;

    sorted_list_checker board = new();

    sorted_insert_list #(
        .CAPACITY   (LIST_DEPTH),
        .VALUE_WIDTH(32)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_req      (req),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_res      (res)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("Timed out with %0d results outstanding", board.pending());
        $display("sorted_insert_list: mismatch");
        $finish;
    end

    // Result side: check on each handshake, then pick the next ready value.
    int unsigned stall_cycle = 0;
    int unsigned stall_mode  = 0;

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            board.check_result(res);
        end
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 97 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ((stall_cycle % 16) >= 6);
        endcase
    end

    function automatic t_req make_add(logic signed [31:0] v);
        t_req r;
        r.req_type = REQ_ADD;
        r.value    = v;
        return r;
    endfunction

    function automatic t_req make_pop();
        t_req r;
        r.req_type = REQ_POP;
        r.value    = $urandom;
        return r;
    endfunction

    // Mix of wide values, a narrow band that yields many duplicates, and extremes.
    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6: return $urandom_range(0, 8) - 4;
            7: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom_range(0, 15) +
                            ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFF0);
        endcase
    endfunction

    // Holds the request until it is taken; valid stays high for the caller.
    task automatic send_request(input t_req r);
        in_valid <= 1'b1;
        req      <= r;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        board.note_request(r);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    initial begin
        int          k;
        int unsigned sent;
        int unsigned burst_left;
        int unsigned phase_left;
        int unsigned add_pct;
        int unsigned gap;
        int unsigned guard;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pop from an empty list, extremes and duplicates, fill to
        // capacity, one add on the full list, then pops that return the smallest values.
        send_request(make_pop());
        send_request(make_add(32'sh7FFF_FFFF));
        send_request(make_add(32'sh8000_0000));
        send_request(make_add(0));
        send_request(make_add(-1));
        send_request(make_add(0));
        send_request(make_add(0));
        for (k = 0; k < 10; k++) begin
            send_request(make_add(k * 1000 - 4000));
        end
        send_request(make_add(5));
        repeat (4) send_request(make_pop());
        wait_for_drain();

        sent       = 0;
        burst_left = 0;
        phase_left = 0;
        add_pct    = 50;
        while (sent < RANDOM_REQUESTS) begin
            // Phases lean towards filling or draining so both ends are hit often.
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 60);
                case ($urandom_range(0, 3))
                    0: add_pct = 85;
                    1: add_pct = 15;
                    2: add_pct = 50;
                    default: add_pct = 65;
                endcase
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    pause_sender(gap);
                end
            end
            if ($urandom_range(1, 100) <= add_pct) begin
                send_request(make_add(random_value()));
            end else begin
                send_request(make_pop());
            end
            sent++;
            phase_left--;
            burst_left--;
            if (sent % 250 == 249) begin
                wait_for_drain();
            end
        end

        in_valid <= 1'b0;
        guard = 0;
        while (board.pending() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        board.flush_leftovers();

        $display("Exercised %0d adds (%0d refused on a full list) and %0d pops (%0d on an empty list).",
                 board.adds_done + board.adds_refused, board.adds_refused,
                 board.pops_done + board.pops_refused, board.pops_refused);
        $display("List filled to %0d of %0d entries; %0d field mismatches logged.",
                 board.deepest, LIST_DEPTH, board.mismatches);
        if (board.mismatches == 0) begin
            $display("sorted_insert_list: match");
        end else begin
            $display("sorted_insert_list: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/sil_pkg.sv
rtl/core/sil_cell.sv
rtl/core/sorted_insert_list.sv
dv/sil_tb_pkg.sv
dv/tb_top.sv
